### hdl/fdr_pkg.sv
// Shared widths, stage bus types and constants for the dielectric reflectance block.
// No dependencies.
package fdr_pkg;

    localparam int unsigned CosW     = 16;
    localparam int unsigned IdxW     = 16;
    localparam int unsigned ProdW    = CosW + IdxW;
    localparam int unsigned DenW     = ProdW + 1;
    localparam int unsigned RemW     = DenW + 1;
    localparam int unsigned FracBits = 15;
    localparam int unsigned QuoW     = FracBits + 1;
    localparam int unsigned NumCells = QuoW;
    localparam int unsigned SqW      = 2 * QuoW;
    localparam int unsigned ReflW    = 16;

    localparam logic [ReflW-1:0] ONE_Q15 = ReflW'(1 << FracBits);

    // One amplitude ratio in flight through the divider row.
    typedef struct packed {
        logic [RemW-1:0] rem;
        logic [DenW-1:0] den;
        logic [QuoW-1:0] quo;
    } t_div;

    typedef struct packed {
        logic valid;
        logic degen;
    } t_ctl;

    typedef struct packed {
        t_ctl ctl;
        t_div par;
        t_div perp;
    } t_cell_bus;

endpackage

### hdl/fdr_in_if.sv
// Input channel: cosines and refractive indices with valid/ready.
// Depends on fdr_pkg.
interface fdr_in_if;
    import fdr_pkg::*;

    logic            valid;
    logic            ready;
    logic [CosW-1:0] cos_incident;
    logic [CosW-1:0] cos_transmitted;
    logic [IdxW-1:0] index_incident;
    logic [IdxW-1:0] index_transmitted;

    modport source (
        output valid, cos_incident, cos_transmitted, index_incident, index_transmitted,
        input  ready
    );
    modport sink (
        input  valid, cos_incident, cos_transmitted, index_incident, index_transmitted,
        output ready
    );
endinterface

### hdl/fdr_out_if.sv
// Output channel: reflectance and degenerate flag with valid/ready.
// Depends on fdr_pkg.
interface fdr_out_if;
    import fdr_pkg::*;

    logic             valid;
    logic             ready;
    logic [ReflW-1:0] reflectance;
    logic             degenerate;

    modport source (output valid, reflectance, degenerate, input ready);
    modport sink   (input valid, reflectance, degenerate, output ready);
endinterface

### hdl/fdr_front.sv
// Front end: four cosine-index products, then denominators, difference magnitudes
// and the zero-denominator flag. Two register stages. Depends on fdr_pkg.
module fdr_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [fdr_pkg::CosW-1:0] i_cos_incident,
    input  logic [fdr_pkg::CosW-1:0] i_cos_transmitted,
    input  logic [fdr_pkg::IdxW-1:0] i_index_incident,
    input  logic [fdr_pkg::IdxW-1:0] i_index_transmitted,
    output fdr_pkg::t_cell_bus     o_bus
);
    import fdr_pkg::*;

    logic [ProdW-1:0] r_p, r_q, r_s, r_t;
    logic             r_prod_valid;
    t_cell_bus        r_bus;
    t_cell_bus        n_bus;

    logic [DenW-1:0]  sum_par, sum_perp;
    logic [ProdW-1:0] diff_par, diff_perp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else if (i_en) begin
            r_prod_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= ProdW'(i_index_transmitted) * ProdW'(i_cos_incident);
            r_q <= ProdW'(i_index_incident) * ProdW'(i_cos_transmitted);
            r_s <= ProdW'(i_index_incident) * ProdW'(i_cos_incident);
            r_t <= ProdW'(i_index_transmitted) * ProdW'(i_cos_transmitted);
        end
    end

    always_comb begin
        sum_par   = DenW'(r_p) + DenW'(r_q);
        sum_perp  = DenW'(r_s) + DenW'(r_t);
        // Sign drops out once the ratio is squared: keep the magnitude only.
        diff_par  = (r_p >= r_q) ? (r_p - r_q) : (r_q - r_p);
        diff_perp = (r_s >= r_t) ? (r_s - r_t) : (r_t - r_s);

        n_bus.ctl.valid = r_prod_valid;
        n_bus.ctl.degen = (sum_par == '0) || (sum_perp == '0);
        n_bus.par.rem   = RemW'(diff_par);
        n_bus.par.den   = sum_par;
        n_bus.par.quo   = '0;
        n_bus.perp.rem  = RemW'(diff_perp);
        n_bus.perp.den  = sum_perp;
        n_bus.perp.quo  = '0;
    end

    // Reset clears the valid bit only; payload holds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

### hdl/fdr_cell.sv
// One restoring-division cell: resolves one quotient bit of both ratios and
// hands the shifted remainders to the next cell. Depends on fdr_pkg.
module fdr_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  fdr_pkg::t_cell_bus i_bus,
    output fdr_pkg::t_cell_bus o_bus
);
    import fdr_pkg::*;

    t_cell_bus r_bus;
    t_cell_bus n_bus;

    function automatic t_div div_step(input t_div d);
        t_div            res;
        logic            ge;
        logic [RemW-1:0] kept;
        ge       = d.rem >= RemW'(d.den);
        kept     = ge ? (d.rem - RemW'(d.den)) : d.rem;
        // Remainder stays below den, so the shift cannot overflow.
        res.rem  = {kept[RemW-2:0], 1'b0};
        res.den  = d.den;
        res.quo  = {d.quo[QuoW-2:0], ge};
        return res;
    endfunction

    always_comb begin
        n_bus.ctl  = i_bus.ctl;
        n_bus.par  = div_step(i_bus.par);
        n_bus.perp = div_step(i_bus.perp);
    end

    // Reset clears the valid bit only; payload holds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

### hdl/fdr_chain.sv
// Row of division cells, one quotient bit per cell, MSB first.
// Depends on fdr_pkg and fdr_cell.
module fdr_chain (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  fdr_pkg::t_cell_bus i_bus,
    output fdr_pkg::t_cell_bus o_bus
);
    import fdr_pkg::*;

    t_cell_bus link [0:NumCells];

    assign link[0] = i_bus;

    for (genvar g = 0; g < NumCells; g++) begin : g_cell
        fdr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_bus   (link[g]),
            .o_bus   (link[g+1])
        );
    end

    assign o_bus = link[NumCells];

endmodule

### hdl/fresnel_dielectric_reflectance.sv
// Unpolarized Fresnel reflectance at a dielectric boundary, one wavelength per item.
//
// Channels: i_in carries cos_incident, cos_transmitted (UQ1.15) and
// index_incident, index_transmitted (UQ4.12); o_out carries reflectance (UQ1.15)
// and degenerate. Each side transfers when valid and ready are both high.
// Throughput: one item per cycle while the output is not stalled. Pipeline: one
// product stage, one sum stage, 16 division cells (one quotient bit each), one
// squaring stage and the output register.
// Every item gives exactly one result. A zero denominator forces reflectance
// to 1.0 and sets degenerate.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// i_in.ready drops; it advances again in the cycle the result is taken.
// Reset (i_rst_n low, synchronous) empties every stage; payload is not cleared.
//
// Depends on fdr_pkg, fdr_in_if, fdr_out_if, fdr_front, fdr_chain, fdr_cell.
module fresnel_dielectric_reflectance (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fdr_in_if.sink    i_in,
    fdr_out_if.source o_out
);
    import fdr_pkg::*;

    logic      en;
    t_cell_bus front_bus;
    t_cell_bus chain_bus;

    logic [SqW-1:0]   r_sq_par, r_sq_perp;
    logic             r_sq_valid;
    logic             r_sq_degen;
    logic [SqW:0]     sq_sum;
    logic [ReflW-1:0] n_refl;
    logic [ReflW-1:0] r_refl;
    logic             r_degen;
    logic             r_out_valid;

    // Advance whenever the output register is free or being drained.
    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    fdr_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_en                (en),
        .i_valid             (i_in.valid),
        .i_cos_incident      (i_in.cos_incident),
        .i_cos_transmitted   (i_in.cos_transmitted),
        .i_index_incident    (i_in.index_incident),
        .i_index_transmitted (i_in.index_transmitted),
        .o_bus               (front_bus)
    );

    fdr_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_bus   (front_bus),
        .o_bus   (chain_bus)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_sq_valid  <= chain_bus.ctl.valid;
            r_out_valid <= r_sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_par   <= SqW'(chain_bus.par.quo) * SqW'(chain_bus.par.quo);
            r_sq_perp  <= SqW'(chain_bus.perp.quo) * SqW'(chain_bus.perp.quo);
            r_sq_degen <= chain_bus.ctl.degen;
        end
    end

    always_comb begin
        sq_sum = (SqW+1)'(r_sq_par) + (SqW+1)'(r_sq_perp);
        // Halve and drop back to 15 fraction bits in one shift.
        n_refl = r_sq_degen ? ONE_Q15 : sq_sum[ReflW+FracBits:FracBits+1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_refl  <= n_refl;
            r_degen <= r_sq_degen;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.reflectance = r_refl;
    assign o_out.degenerate  = r_degen;

    a_degen_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.degenerate |-> o_out.reflectance == ONE_Q15)
        else $error("degenerate result without full reflectance");

    a_refl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.reflectance <= ONE_Q15)
        else $error("reflectance above 1.0");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid && !o_out.ready)
        else $error("input stalled while output register free");

    a_sq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_valid && !r_sq_degen |-> sq_sum[SqW] == 1'b0)
        else $error("sum of squared ratios out of range");

endmodule
